### src/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int DATA_W   = 32;

    typedef logic [2:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_INSERT = 3'd0;
    localparam opcode_t OP_DELETE = 3'd1;
    localparam opcode_t OP_GET    = 3'd2;
    localparam opcode_t OP_LOCATE = 3'd3;
    localparam opcode_t OP_CLEAR  = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   read_value;
        logic [7:0]          found_position;
        logic [7:0]          count;
        logic                is_empty;
    } res_t;

endpackage

### src/sle_ram.sv
`timescale 1ns / 1ps

module sle_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/sle_seq.sv
`timescale 1ns / 1ps

module sle_seq
    import sle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  opcode_t           opcode,
    input  logic [7:0]        position,
    input  logic [DATA_W-1:0] item_value,
    input  logic              out_free,
    output logic              res_valid,
    output res_t              res,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [DATA_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [DATA_W-1:0] ram_rdata
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STREAM = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    opcode_t           op_reg, op_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic              up_reg, up_next;
    logic              issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [7:0]        found_reg, found_next;

    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic [ADDR_W-1:0] pos_idx;
    logic [ADDR_W-1:0] cnt_m1;
    logic              pos_nz;

    assign pos_c   = CMP_W'(position);
    assign cnt_c   = CMP_W'(count_reg);
    assign pos_idx = ADDR_W'(position - 8'd1);
    assign cnt_m1  = ADDR_W'(count_reg - CNT_W'(1));
    assign pos_nz  = (position != 8'd0);

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        k_next       = k_reg;
        val_next     = val_reg;
        rd_addr_next = rd_addr_reg;
        end_next     = end_reg;
        up_next      = up_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        prev_next    = prev_reg;
        rd_next      = rd_reg;
        found_next   = found_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = rd_addr_reg;
        res_valid    = 1'b0;
        res          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = opcode;
                    k_next      = pos_idx;
                    val_next    = item_value;
                    status_next = ST_OK;
                    rd_next     = '0;
                    found_next  = '0;
                    issue_next  = 1'b1;
                    state_next  = S_FINISH;
                    case (opcode) inside
                        OP_INSERT:
                        begin
                            if (!pos_nz || pos_c > cnt_c + CMP_W'(1))
                                status_next = ST_RANGE;
                            else if (count_reg == CNT_W'(CAPACITY))
                                status_next = ST_FULL;
                            else if (pos_c != cnt_c + CMP_W'(1))
                            begin
                                // shift tail up, walking down from the last entry
                                rd_addr_next = cnt_m1;
                                end_next     = pos_idx;
                                up_next      = 1'b0;
                                state_next   = S_STREAM;
                            end
                        end
                        OP_DELETE, OP_GET:
                        begin
                            if (!pos_nz || pos_c > cnt_c)
                                status_next = ST_RANGE;
                            else
                            begin
                                rd_addr_next = pos_idx;
                                end_next     = (opcode == OP_GET) ? pos_idx : cnt_m1;
                                up_next      = 1'b1;
                                state_next   = S_STREAM;
                            end
                        end
                        OP_LOCATE:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_addr_next = '0;
                                end_next     = cnt_m1;
                                up_next      = 1'b1;
                                state_next   = S_STREAM;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_STREAM:
            begin
                if (issue_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    prev_next = rd_addr_reg;
                    if (rd_addr_reg == end_reg)
                        issue_next = 1'b0;
                    else if (up_reg)
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                    else
                        rd_addr_next = rd_addr_reg - ADDR_W'(1);
                end

                if (pend_reg)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = prev_reg + ADDR_W'(1);
                            ram_wdata = ram_rdata;
                        end
                        OP_DELETE:
                        begin
                            if (prev_reg == k_reg)
                                rd_next = ram_rdata;
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = prev_reg - ADDR_W'(1);
                                ram_wdata = ram_rdata;
                            end
                        end
                        OP_GET:
                        begin
                            rd_next = ram_rdata;
                        end
                        OP_LOCATE:
                        begin
                            if (ram_rdata == val_reg)
                            begin
                                // first match ends the scan
                                found_next = 8'(prev_reg) + 8'd1;
                                issue_next = 1'b0;
                                pend_next  = 1'b0;
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (!issue_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    if (status_reg == ST_OK)
                    begin
                        case (op_reg)
                            OP_INSERT:
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = k_reg;
                                ram_wdata  = val_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                            OP_DELETE: count_next = count_reg - CNT_W'(1);
                            OP_CLEAR:  count_next = '0;
                            default:
                            begin
                            end
                        endcase
                    end
                    res_valid          = 1'b1;
                    res.status         = status_reg;
                    res.read_value     = rd_reg;
                    res.found_position = found_reg;
                    res.count          = 8'(count_next);
                    res.is_empty       = (count_next == '0);
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        status_reg  <= status_next;
        k_reg       <= k_next;
        val_reg     <= val_next;
        rd_addr_reg <= rd_addr_next;
        end_reg     <= end_next;
        up_reg      <= up_next;
        prev_reg    <= prev_next;
        rd_reg      <= rd_next;
        found_reg   <= found_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("RAM write while idle");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("read data left pending at idle");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_FULL) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && op_reg == OP_INSERT && res.status == ST_OK)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

endmodule

### src/sequential_list_engine_unit.sv
`timescale 1ns / 1ps

// Ordered list of up to 128 signed words kept in a single-port-read,
// single-port-write RAM. Each item takes one command and gives one result.
// The RAM read port moves or compares one entry per cycle: insert shifts
// from the last entry down to position p (none when appending), delete
// from p to the last, get reads p, locate scans from the first and stops
// at the first match; clear, unused opcodes and rejected commands skip the
// RAM. A result waits in an output register while the next item is taken.
module sequential_list_engine_unit
    import sle_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [2:0]               opcode,
    input  logic [7:0]               position,
    input  logic signed [31:0]       item_value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic [1:0]               status,
    output logic signed [31:0]       read_value,
    output logic [7:0]               found_position,
    output logic [7:0]               count,
    output logic                     is_empty
);

    logic              out_free;
    logic              res_valid;
    res_t              res;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              rsp_valid_reg;
    res_t              rsp_reg;

    assign out_free = !rsp_valid_reg || rsp_ready;

    sle_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .opcode     (opcode),
        .position   (position),
        .item_value (item_value),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    sle_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (res_valid)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            rsp_reg <= res;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_reg.status;
    assign read_value     = rsp_reg.read_value;
    assign found_position = rsp_reg.found_position;
    assign count          = rsp_reg.count;
    assign is_empty       = rsp_reg.is_empty;

endmodule
